FILE: rtl/cci_pkg.sv
//------------------------------------------------------------------------------
// cci_pkg
// widths, status codes, pipeline bundles and helpers for the circle-circle
// intersection pipeline
//------------------------------------------------------------------------------
`default_nettype none

package cci_pkg;

	localparam int CW  = 32;
	localparam int RW  = CW - 1;
	localparam int MW  = CW + 1;
	localparam int D2W = 2 * MW;
	localparam int KMW = 2 * CW + 1;
	localparam int SW  = 2 * CW;
	localparam int HW  = 4 * CW;
	localparam int RMW = SW + 2;
	localparam int PW  = KMW + MW;
	localparam int NMW = PW + 1;
	localparam int QW  = CW - 1;
	localparam int XW  = 2 * MW + 1;

	localparam logic [1:0] ST_FOUND  = 2'd0;
	localparam logic [1:0] ST_FAR    = 2'd1;
	localparam logic [1:0] ST_NESTED = 2'd2;
	localparam logic [1:0] ST_SAME   = 2'd3;

	typedef struct packed {
		logic [1:0]           status;
		logic signed [CW-1:0] cx0;
		logic signed [CW-1:0] cy0;
		logic signed [CW-1:0] qx;
		logic signed [CW-1:0] qy;
		logic                 xneg;
		logic                 xzero;
		logic                 dxn;
		logic                 dyn;
		logic                 kn;
		logic [MW-1:0]        dxm;
		logic [MW-1:0]        dym;
		logic [SW-1:0]        d2;
		logic [KMW-1:0]       km;
		logic [PW-1:0]        kdxm;
		logic [PW-1:0]        kdym;
	} carry_t;

	typedef struct packed {
		carry_t         c;
		logic [HW-1:0]  h;
		logic [SW-1:0]  root;
		logic [RMW-1:0] rem;
	} sq_t;

	typedef struct packed {
		carry_t        c;
		logic          snz;
		logic          nxn;
		logic          nyn;
		logic [NMW:0]  mx;
		logic [NMW:0]  my;
		logic [QW-1:0] quox;
		logic [QW-1:0] quoy;
	} dv_t;

	function automatic logic signed [NMW:0] sval(input logic neg, input logic [NMW-1:0] m);
		logic signed [NMW:0] v;
		v = $signed({1'b0, m});
		return neg ? -v : v;
	endfunction

	function automatic logic signed [CW-1:0] sat(input logic signed [CW:0] v);
		logic signed [CW-1:0] r;
		if (v[CW] != v[CW-1]) begin
			r = v[CW] ? {1'b1, {(CW-1){1'b0}}} : {1'b0, {(CW-1){1'b1}}};
		end else begin
			r = v[CW-1:0];
		end
		return r;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/circle_circle_intersection_top.sv
//------------------------------------------------------------------------------
// circle_circle_intersection_top
// intersection of two circles, nearest to a reference point, as a deep
// pipeline with exact wide integer arithmetic
//------------------------------------------------------------------------------
// One transaction in, one transaction out, in order; a new item can enter in
// every cycle while the output is not stalled. The pipeline has six stages of
// differences, squares and products, a square root that resolves one root bit
// per stage over 2*CW+1 registers, three stages forming the two numerators, and
// a restoring divider that resolves one quotient bit per stage over CW
// registers, then the output register. A stalled output holds the whole
// pipeline; the input stall is raised only then.
`default_nettype none

module circle_circle_intersection_top (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [cci_pkg::CW-1:0] first_center_x,
	input  logic signed [cci_pkg::CW-1:0] first_center_y,
	input  logic        [cci_pkg::RW-1:0] first_radius,
	input  logic signed [cci_pkg::CW-1:0] second_center_x,
	input  logic signed [cci_pkg::CW-1:0] second_center_y,
	input  logic        [cci_pkg::RW-1:0] second_radius,
	input  logic signed [cci_pkg::CW-1:0] reference_x,
	input  logic signed [cci_pkg::CW-1:0] reference_y,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic signed [cci_pkg::CW-1:0] point_x,
	output logic signed [cci_pkg::CW-1:0] point_y,
	output logic [1:0]                    status
);
	import cci_pkg::*;

	logic en;
	assign en       = !(out_valid && out_stall);
	assign in_stall = !en;

	// stage 1: differences
	logic                 v_s1;
	logic signed [CW-1:0] cx0_s1, cy0_s1, qx_s1, qy_s1;
	logic [RW-1:0]        r0_s1, r1_s1, rd_s1;
	logic [CW-1:0]        rs_s1;
	logic signed [CW:0]   dx_s1, dy_s1, rx_s1, ry_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cx0_s1 <= first_center_x;
			cy0_s1 <= first_center_y;
			qx_s1  <= reference_x;
			qy_s1  <= reference_y;
			r0_s1  <= first_radius;
			r1_s1  <= second_radius;
			dx_s1  <= $signed({second_center_x[CW-1], second_center_x})
				- $signed({first_center_x[CW-1], first_center_x});
			dy_s1  <= $signed({second_center_y[CW-1], second_center_y})
				- $signed({first_center_y[CW-1], first_center_y});
			rx_s1  <= $signed({reference_x[CW-1], reference_x})
				- $signed({first_center_x[CW-1], first_center_x});
			ry_s1  <= $signed({reference_y[CW-1], reference_y})
				- $signed({first_center_y[CW-1], first_center_y});
			rs_s1  <= {1'b0, first_radius} + {1'b0, second_radius};
			rd_s1  <= (first_radius > second_radius) ? first_radius - second_radius
				: second_radius - first_radius;
		end
	end

	// stage 2: squares and cross products
	logic                    v_s2, req_s2;
	carry_t                  car_s2, car2_c;
	logic [D2W-1:0]          dx2_s2, dy2_s2;
	logic [2*CW-1:0]         rs2_s2;
	logic [2*RW-1:0]         rd2_s2, r0sq_s2, r1sq_s2;
	logic signed [2*MW-1:0]  crx_s2, cry_s2;
	logic [MW-1:0]           dxm_c, dym_c;

	assign dxm_c = dx_s1[CW] ? MW'(-dx_s1) : MW'(dx_s1);
	assign dym_c = dy_s1[CW] ? MW'(-dy_s1) : MW'(dy_s1);

	always_comb begin
		car2_c     = '0;
		car2_c.cx0 = cx0_s1;
		car2_c.cy0 = cy0_s1;
		car2_c.qx  = qx_s1;
		car2_c.qy  = qy_s1;
		car2_c.dxn = dx_s1[CW];
		car2_c.dyn = dy_s1[CW];
		car2_c.dxm = dxm_c;
		car2_c.dym = dym_c;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			car_s2        <= car2_c;
			req_s2        <= (r0_s1 == r1_s1);
			dx2_s2        <= dxm_c * dxm_c;
			dy2_s2        <= dym_c * dym_c;
			rs2_s2        <= rs_s1 * rs_s1;
			rd2_s2        <= rd_s1 * rd_s1;
			r0sq_s2       <= r0_s1 * r0_s1;
			r1sq_s2       <= r1_s1 * r1_s1;
			crx_s2        <= rx_s1 * dy_s1;
			cry_s2        <= ry_s1 * dx_s1;
		end
	end

	// stage 3: squared distance and side of the reference
	logic              v_s3, req_s3;
	carry_t            car_s3, car3_c;
	logic [D2W-1:0]    d2_s3;
	logic [2*CW-1:0]   rs2_s3;
	logic [2*RW-1:0]   rd2_s3, r0sq_s3, r1sq_s3;
	logic signed [XW-1:0] cr_c;

	assign cr_c = XW'(crx_s2) - XW'(cry_s2);

	always_comb begin
		car3_c       = car_s2;
		car3_c.xneg  = cr_c[XW-1];
		car3_c.xzero = (cr_c == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			car_s3       <= car3_c;
			d2_s3        <= dx2_s2 + dy2_s2;
			rs2_s3       <= rs2_s2;
			rd2_s3       <= rd2_s2;
			r0sq_s3      <= r0sq_s2;
			r1sq_s3      <= r1sq_s2;
			req_s3       <= req_s2;
		end
	end

	// stage 4: classification and K
	logic            v_s4;
	carry_t          car_s4, car4_c;
	logic [2*RW-1:0] r0sq_s4;
	logic [1:0]      st_c;
	logic [D2W+1:0]  k_c, kabs_c;

	always_comb begin
		if (d2_s3 > rs2_s3) begin
			st_c = ST_FAR;
		end else if (d2_s3 < rd2_s3) begin
			st_c = ST_NESTED;
		end else if (d2_s3 == '0 && req_s3) begin
			st_c = ST_SAME;
		end else begin
			st_c = ST_FOUND;
		end
	end

	assign k_c    = (D2W+2)'(d2_s3) + (D2W+2)'(r0sq_s3) - (D2W+2)'(r1sq_s3);
	assign kabs_c = k_c[D2W+1] ? -k_c : k_c;

	always_comb begin
		car4_c        = car_s3;
		car4_c.status = st_c;
		car4_c.d2     = d2_s3[SW-1:0];
		car4_c.kn     = k_c[D2W+1];
		car4_c.km     = kabs_c[KMW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			car_s4        <= car4_c;
			r0sq_s4       <= r0sq_s3;
		end
	end

	// stage 5: partial products of 4*r0^2*D2, K^2, K*dx, K*dy
	logic                 v_s5;
	carry_t               car_s5;
	logic [RW+CW-1:0]     pa00_s5, pa01_s5, pa10_s5, pa11_s5;
	logic [2*CW-1:0]      pk0_s5;
	logic [2*CW:0]        pk1_s5;
	logic [2*CW+1:0]      pk2_s5;
	logic [CW+MW-1:0]     pkx0_s5, pky0_s5;
	logic [CW+MW:0]       pkx1_s5, pky1_s5;
	logic [CW-1:0]        klo_c;
	logic [CW:0]          khi_c;

	assign klo_c = car_s4.km[CW-1:0];
	assign khi_c = car_s4.km[KMW-1:CW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			car_s5  <= car_s4;
			pa00_s5 <= r0sq_s4[RW-1:0] * car_s4.d2[CW-1:0];
			pa01_s5 <= r0sq_s4[RW-1:0] * car_s4.d2[SW-1:CW];
			pa10_s5 <= r0sq_s4[2*RW-1:RW] * car_s4.d2[CW-1:0];
			pa11_s5 <= r0sq_s4[2*RW-1:RW] * car_s4.d2[SW-1:CW];
			pk0_s5  <= klo_c * klo_c;
			pk1_s5  <= klo_c * khi_c;
			pk2_s5  <= khi_c * khi_c;
			pkx0_s5 <= klo_c * car_s4.dxm;
			pkx1_s5 <= khi_c * car_s4.dxm;
			pky0_s5 <= klo_c * car_s4.dym;
			pky1_s5 <= khi_c * car_s4.dym;
		end
	end

	// stage 6: product sums
	logic             v_s6;
	carry_t           car_s6, car6_c;
	logic [HW-1:0]    a_s6;
	logic [2*KMW-1:0] kk_s6;

	always_comb begin
		car6_c      = car_s5;
		car6_c.kdxm = (PW'(pkx1_s5) << CW) + PW'(pkx0_s5);
		car6_c.kdym = (PW'(pky1_s5) << CW) + PW'(pky0_s5);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s6 <= 1'b0;
		end else if (en) begin
			v_s6 <= v_s5;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			car_s6      <= car6_c;
			a_s6        <= (HW'(pa11_s5) << (RW + CW + 2)) + (HW'(pa10_s5) << (RW + 2))
				+ (HW'(pa01_s5) << (CW + 2)) + (HW'(pa00_s5) << 2);
			kk_s6       <= ((2*KMW)'(pk2_s5) << (2*CW)) + ((2*KMW)'(pk1_s5) << (CW + 1))
				+ (2*KMW)'(pk0_s5);
		end
	end

	// stage 7: radicand, then one root bit per sub-stage
	logic [SW:0]      sqv_s7;
	sq_t              sq_s7 [SW+1];
	logic [2*KMW-1:0] ae_c;
	logic [HW-1:0]    h2_c;

	assign ae_c = (2*KMW)'(a_s6);
	assign h2_c = (ae_c > kk_s6) ? HW'(ae_c - kk_s6) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sqv_s7 <= '0;
		end else if (en) begin
			sqv_s7 <= {sqv_s7[SW-1:0], v_s6};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sq_s7[0].c    <= car_s6;
			sq_s7[0].h    <= h2_c;
			sq_s7[0].root <= '0;
			sq_s7[0].rem  <= '0;
		end
	end

	for (genvar j = 0; j < SW; j++) begin : g_sqrt
		logic [RMW-1:0] t_c, trial_c;
		sq_t            nxt_c;

		assign t_c     = {sq_s7[j].rem[SW-1:0], sq_s7[j].h[HW-1:HW-2]};
		assign trial_c = {sq_s7[j].root, 2'b01};

		always_comb begin
			nxt_c   = sq_s7[j];
			nxt_c.h = {sq_s7[j].h[HW-3:0], 2'b00};
			if (t_c >= trial_c) begin
				nxt_c.rem  = t_c - trial_c;
				nxt_c.root = {sq_s7[j].root[SW-2:0], 1'b1};
			end else begin
				nxt_c.rem  = t_c;
				nxt_c.root = {sq_s7[j].root[SW-2:0], 1'b0};
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				sq_s7[j+1] <= nxt_c;
			end
		end
	end

	// stage 8: partial products of S*dx, S*dy
	logic             v_s8, snz_s8;
	carry_t           car_s8;
	logic [CW+MW-1:0] sx0_s8, sx1_s8, sy0_s8, sy1_s8;
	logic [SW-1:0]    sroot_c;

	assign sroot_c = sq_s7[SW].root;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s8 <= 1'b0;
		end else if (en) begin
			v_s8 <= sqv_s7[SW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			car_s8 <= sq_s7[SW].c;
			snz_s8 <= (sroot_c != '0);
			sx0_s8 <= sroot_c[CW-1:0] * sq_s7[SW].c.dxm;
			sx1_s8 <= sroot_c[SW-1:CW] * sq_s7[SW].c.dxm;
			sy0_s8 <= sroot_c[CW-1:0] * sq_s7[SW].c.dym;
			sy1_s8 <= sroot_c[SW-1:CW] * sq_s7[SW].c.dym;
		end
	end

	// stage 9: S*dx, S*dy
	logic             v_s9, snz_s9;
	carry_t           car_s9;
	logic [SW+MW-1:0] sdx_s9, sdy_s9;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s9 <= 1'b0;
		end else if (en) begin
			v_s9 <= v_s8;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			car_s9 <= car_s8;
			snz_s9 <= snz_s8;
			sdx_s9 <= ((SW+MW)'(sx1_s8) << CW) + (SW+MW)'(sx0_s8);
			sdy_s9 <= ((SW+MW)'(sy1_s8) << CW) + (SW+MW)'(sy0_s8);
		end
	end

	// stage 10: signed numerators, candidate picked by side of the reference
	logic                v_s10, snz_s10;
	carry_t              car_s10;
	logic signed [NMW:0] nx_s10, ny_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s10 <= 1'b0;
		end else if (en) begin
			v_s10 <= v_s9;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			car_s10 <= car_s9;
			snz_s10 <= snz_s9;
			nx_s10  <= sval(car_s9.kn ^ car_s9.dxn, NMW'(car_s9.kdxm))
				+ sval(car_s9.dyn ^ car_s9.xneg, NMW'(sdy_s9));
			ny_s10  <= sval(car_s9.kn ^ car_s9.dyn, NMW'(car_s9.kdym))
				+ sval(!(car_s9.dxn ^ car_s9.xneg), NMW'(sdx_s9));
		end
	end

	// stage 11: rounding bias, then one quotient bit per sub-stage
	logic [QW:0]  dvv_s11;
	dv_t          dv_s11 [QW+1];
	logic [NMW:0] d2e_c, nxu_c, nyu_c;

	assign d2e_c = (NMW+1)'(car_s10.d2);
	assign nxu_c = nx_s10;
	assign nyu_c = ny_s10;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dvv_s11 <= '0;
		end else if (en) begin
			dvv_s11 <= {dvv_s11[QW-1:0], v_s10};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dv_s11[0].c    <= car_s10;
			dv_s11[0].snz  <= snz_s10;
			dv_s11[0].nxn  <= nx_s10[NMW];
			dv_s11[0].nyn  <= ny_s10[NMW];
			dv_s11[0].mx   <= nx_s10[NMW] ? d2e_c - nxu_c : nxu_c + d2e_c;
			dv_s11[0].my   <= ny_s10[NMW] ? d2e_c - nyu_c : nyu_c + d2e_c;
			dv_s11[0].quox <= '0;
			dv_s11[0].quoy <= '0;
		end
	end

	for (genvar k = 0; k < QW; k++) begin : g_div
		localparam int B = QW - 1 - k;
		logic [NMW:0] dsh_c;
		dv_t          nxt_c;

		assign dsh_c = {{(NMW-SW){1'b0}}, dv_s11[k].c.d2, 1'b0} << B;

		always_comb begin
			nxt_c = dv_s11[k];
			if (dv_s11[k].mx >= dsh_c) begin
				nxt_c.mx      = dv_s11[k].mx - dsh_c;
				nxt_c.quox[B] = 1'b1;
			end
			if (dv_s11[k].my >= dsh_c) begin
				nxt_c.my      = dv_s11[k].my - dsh_c;
				nxt_c.quoy[B] = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s11[k+1] <= nxt_c;
			end
		end
	end

	// output register
	dv_t                fin_c;
	logic signed [CW:0] vx_c, vy_c, cxe_c, cye_c, qxe_c, qye_c;

	assign fin_c = dv_s11[QW];
	assign cxe_c = {fin_c.c.cx0[CW-1], fin_c.c.cx0};
	assign cye_c = {fin_c.c.cy0[CW-1], fin_c.c.cy0};
	assign qxe_c = $signed({2'b00, fin_c.quox});
	assign qye_c = $signed({2'b00, fin_c.quoy});
	assign vx_c  = fin_c.nxn ? cxe_c - qxe_c : cxe_c + qxe_c;
	assign vy_c  = fin_c.nyn ? cye_c - qye_c : cye_c + qye_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (en) begin
			out_valid <= dvv_s11[QW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			status <= fin_c.c.status;
			if (fin_c.c.status != ST_FOUND) begin
				point_x <= '0;
				point_y <= '0;
			end else if (fin_c.snz && fin_c.c.xzero) begin
				point_x <= fin_c.c.qx;
				point_y <= fin_c.c.qy;
			end else begin
				point_x <= sat(vx_c);
				point_y <= sat(vy_c);
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_zero_unless_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && status != ST_FOUND |-> point_x == '0 && point_y == '0)
		else $error("point not zero on a miss");

	a_stall_holds_pipe: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |=> $stable(v_s1) && $stable(dvv_s11))
		else $error("pipeline moved while stalled");

	a_div_remainder: assert property (@(posedge clk) disable iff (!arst_n)
		dvv_s11[QW] && fin_c.c.status == ST_FOUND
		|-> fin_c.mx < {fin_c.c.d2, 1'b0} && fin_c.my < {fin_c.c.d2, 1'b0})
		else $error("divider remainder out of range");
`endif

endmodule

`default_nettype wire
